@@ rtl/core/dll_pkg.sv @@
// Shared types and codes for the doubly linked list engine.
// Depends on nothing; every other file in rtl/core imports it.
package dll_pkg;

   localparam int CMD_W  = 3;
   localparam int POS_W  = 5;
   localparam int DATA_W = 32;
   localparam int STAT_W = 3;
   localparam int LEN_W  = 5;

   // command codes
   localparam logic [CMD_W-1:0] CMD_APPEND    = 3'd0;
   localparam logic [CMD_W-1:0] CMD_INSERT    = 3'd1;
   localparam logic [CMD_W-1:0] CMD_DEL_VALUE = 3'd2;
   localparam logic [CMD_W-1:0] CMD_DEL_HEAD  = 3'd3;
   localparam logic [CMD_W-1:0] CMD_DEL_TAIL  = 3'd4;
   localparam logic [CMD_W-1:0] CMD_DUMP      = 3'd5;

   // status codes
   localparam logic [STAT_W-1:0] ST_OK        = 3'd0;
   localparam logic [STAT_W-1:0] ST_FULL      = 3'd1;
   localparam logic [STAT_W-1:0] ST_BAD_POS   = 3'd2;
   localparam logic [STAT_W-1:0] ST_NOT_FOUND = 3'd3;
   localparam logic [STAT_W-1:0] ST_EMPTY     = 3'd4;

   typedef struct packed {
      logic [STAT_W-1:0]        status;
      logic signed [DATA_W-1:0] item_value;
      logic                     last;
      logic [LEN_W-1:0]         length;
   } rsp_type;

endpackage

@@ rtl/core/dll_req_if.sv @@
// Command channel of the linked list engine: valid/ready plus command payload.
// Depends on dll_pkg for field widths.
interface dll_req_if import dll_pkg::*; ();
   logic                     valid;
   logic                     ready;
   logic [CMD_W-1:0]         command;
   logic [POS_W-1:0]         position;
   logic signed [DATA_W-1:0] value;

   modport source (output valid, output command, output position, output value,
                   input ready);
   modport sink   (input valid, input command, input position, input value,
                   output ready);
endinterface

@@ rtl/core/dll_rsp_if.sv @@
// Result channel of the linked list engine: valid/ready plus result payload.
// Depends on dll_pkg for field widths.
interface dll_rsp_if import dll_pkg::*; ();
   logic                     valid;
   logic                     ready;
   logic [STAT_W-1:0]        status;
   logic signed [DATA_W-1:0] item_value;
   logic                     last;
   logic [LEN_W-1:0]         length;

   modport source (output valid, output status, output item_value, output last,
                   output length, input ready);
   modport sink   (input valid, input status, input item_value, input last,
                   input length, output ready);
endinterface

@@ rtl/core/dll_store.sv @@
// Entry pool of the linked list engine: value, next and prev memories.
// One shared read address with registered read data, one write port per memory.
module dll_store import dll_pkg::*; #(
   parameter int CAPACITY   = 16,
   parameter int VALUE_BITS = 32
) (
   input  logic                          clock,
   input  logic [$clog2(CAPACITY)-1:0]   rd_addr,
   output logic [VALUE_BITS-1:0]         rd_value,
   output logic [$clog2(CAPACITY)-1:0]   rd_next,
   output logic [$clog2(CAPACITY)-1:0]   rd_prev,
   input  logic                          val_we,
   input  logic [$clog2(CAPACITY)-1:0]   val_addr,
   input  logic [VALUE_BITS-1:0]         val_data,
   input  logic                          nxt_we,
   input  logic [$clog2(CAPACITY)-1:0]   nxt_addr,
   input  logic [$clog2(CAPACITY)-1:0]   nxt_data,
   input  logic                          prv_we,
   input  logic [$clog2(CAPACITY)-1:0]   prv_addr,
   input  logic [$clog2(CAPACITY)-1:0]   prv_data
);
   localparam int IW = $clog2(CAPACITY);

   logic [VALUE_BITS-1:0] value_mem [CAPACITY];
   logic [IW-1:0]         next_mem  [CAPACITY];
   logic [IW-1:0]         prev_mem  [CAPACITY];

   logic [VALUE_BITS-1:0] rd_value_ff;
   logic [IW-1:0]         rd_next_ff;
   logic [IW-1:0]         rd_prev_ff;

   always_ff @(posedge clock) begin
      if (val_we) begin
         value_mem[val_addr] <= val_data;
      end
      if (nxt_we) begin
         next_mem[nxt_addr] <= nxt_data;
      end
      if (prv_we) begin
         prev_mem[prv_addr] <= prv_data;
      end
   end

   always_ff @(posedge clock) begin
      rd_value_ff <= value_mem[rd_addr];
      rd_next_ff  <= next_mem[rd_addr];
      rd_prev_ff  <= prev_mem[rd_addr];
   end

   assign rd_value = rd_value_ff;
   assign rd_next  = rd_next_ff;
   assign rd_prev  = rd_prev_ff;

endmodule

@@ rtl/core/dll_out_reg.sv @@
// Output register of the linked list engine; decouples the sequencer from
// result backpressure. Depends on dll_pkg and dll_rsp_if.
module dll_out_reg import dll_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     load,
   input  rsp_type  load_data,
   output logic     free,
   dll_rsp_if.source rsp_chan
);
   logic    valid_ff, valid_in;
   rsp_type data_ff;

   assign free = !valid_ff || rsp_chan.ready;

   always_comb begin
      valid_in = valid_ff;
      if (load) begin
         valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         data_ff <= load_data;
      end
   end

   assign rsp_chan.valid      = valid_ff;
   assign rsp_chan.status     = data_ff.status;
   assign rsp_chan.item_value = data_ff.item_value;
   assign rsp_chan.last       = data_ff.last;
   assign rsp_chan.length     = data_ff.length;

endmodule

@@ rtl/core/bounded_doubly_linked_list_engine_top.sv @@
// Bounded doubly linked list engine: sequencer over the entry pool memories.
// Depends on dll_pkg, dll_req_if, dll_rsp_if, dll_store and dll_out_reg.
//
// Usage:
//   req_chan carries one command per transaction (append, insert at a
//   position, delete by value, delete head, delete tail, dump). rsp_chan
//   returns one transaction per command, or one per entry for a dump, with
//   last set on the final one. Both use valid/ready.
// Sequence from accept until the result is registered:
//   append and insert at the tail: allocate, link at the tail; insert at
//   the head: allocate, link at the head; insert at position p (0 < p <
//   length): allocate, walk to the predecessor, splice in; delete head or
//   tail: read, release; delete by value: walk to the match, release; value
//   not found: walk the whole list; other error results: straight to output.
//   Every walk is set by the shared read port of the pool: one linked entry
//   fetched per cycle through a registered read, a dump only while the output
//   register is free. A new command is taken once the sequencer is back in idle.
// Reset (synchronous, active high) empties the list; the pool needs no
//   clearing pass since fresh entries come from a fill count.
// Stall: results sit in an output register; the next command is accepted
//   while one waits. A stalled dump holds its walk until the register frees.
module bounded_doubly_linked_list_engine_top import dll_pkg::*; #(
   parameter int CAPACITY   = 16,
   parameter int VALUE_BITS = 32
) (
   input  logic       clock,
   input  logic       reset,
   dll_req_if.sink    req_chan,
   dll_rsp_if.source  rsp_chan
);
   localparam int IW    = $clog2(CAPACITY);
   localparam int CW    = $clog2(CAPACITY + 1);
   localparam int CMP_W = (CW > POS_W) ? CW : POS_W;
   localparam int WIDE  = (VALUE_BITS > DATA_W) ? VALUE_BITS : DATA_W;

   // sequencer states
   localparam logic [2:0] S_IDLE      = 3'd0;
   localparam logic [2:0] S_ALLOC     = 3'd1;
   localparam logic [2:0] S_WALK      = 3'd2;
   localparam logic [2:0] S_LINK_TAIL = 3'd3;
   localparam logic [2:0] S_LINK_HEAD = 3'd4;
   localparam logic [2:0] S_LINK_MID  = 3'd5;
   localparam logic [2:0] S_FREE      = 3'd6;
   localparam logic [2:0] S_RESP      = 3'd7;

   // control state
   logic [2:0]  state_ff, state_in;
   logic [IW-1:0] head_ff, head_in;
   logic [IW-1:0] tail_ff, tail_in;
   logic [IW-1:0] free_top_ff, free_top_in;   // top of the stack of returned entries
   logic [CW-1:0] count_ff, count_in;
   logic [CW-1:0] hwm_ff, hwm_in;             // entries ever handed out

   // per-command working registers
   logic [CMD_W-1:0]      cmd_ff, cmd_in;
   logic [POS_W-1:0]      pos_ff, pos_in;
   logic [VALUE_BITS-1:0] val_ff, val_in;
   logic [IW-1:0]         cur_ff, cur_in;     // entry whose read data is on the port
   logic [CW-1:0]         idx_ff, idx_in;     // list position of cur_ff
   logic [IW-1:0]         ent_ff, ent_in;     // entry being linked or released
   logic [IW-1:0]         link_ff, link_in;   // successor for a middle insert
   logic [STAT_W-1:0]     status_ff, status_in;
   logic                  pop_ff, pop_in;

   // pool ports
   logic [IW-1:0]         rd_addr;
   logic [VALUE_BITS-1:0] rd_value;
   logic [IW-1:0]         rd_next, rd_prev;
   logic                  val_we, nxt_we, prv_we;
   logic [IW-1:0]         val_addr, nxt_addr, prv_addr;
   logic [VALUE_BITS-1:0] val_data;
   logic [IW-1:0]         nxt_data, prv_data;

   // output register
   logic    out_load, out_free;
   rsp_type out_data;

   // decode helpers
   logic                   is_full, is_empty, can_pop, idx_last, idx_pred, val_match;
   logic [CMP_W-1:0]       pos_w, pos_req_w, cnt_w;
   logic signed [WIDE-1:0] val_ext, item_ext;

   assign is_full   = count_ff == CW'(CAPACITY);
   assign is_empty  = count_ff == '0;
   assign can_pop   = hwm_ff != count_ff;
   assign pos_w     = CMP_W'(pos_ff);
   assign pos_req_w = CMP_W'(req_chan.position);
   assign cnt_w     = CMP_W'(count_ff);
   assign idx_last  = (idx_ff + CW'(1)) == count_ff;
   assign idx_pred  = (CMP_W'(idx_ff) + CMP_W'(1)) == pos_w;
   assign val_match = rd_value == val_ff;
   assign val_ext   = WIDE'(req_chan.value);
   assign item_ext  = WIDE'($signed(rd_value));

   assign req_chan.ready = state_ff == S_IDLE;

   always_comb begin
      state_in    = state_ff;
      head_in     = head_ff;
      tail_in     = tail_ff;
      free_top_in = free_top_ff;
      count_in    = count_ff;
      hwm_in      = hwm_ff;
      cmd_in      = cmd_ff;
      pos_in      = pos_ff;
      val_in      = val_ff;
      cur_in      = cur_ff;
      idx_in      = idx_ff;
      ent_in      = ent_ff;
      link_in     = link_ff;
      status_in   = status_ff;
      pop_in      = pop_ff;

      rd_addr  = cur_ff;
      val_we   = 1'b0;
      val_addr = ent_ff;
      val_data = val_ff;
      nxt_we   = 1'b0;
      nxt_addr = ent_ff;
      nxt_data = free_top_ff;
      prv_we   = 1'b0;
      prv_addr = ent_ff;
      prv_data = cur_ff;

      out_load            = 1'b0;
      out_data.status     = status_ff;
      out_data.item_value = '0;
      out_data.last       = 1'b1;
      out_data.length     = cnt_w[LEN_W-1:0];

      case (state_ff)
         S_IDLE: begin
            if (req_chan.valid) begin
               cmd_in    = req_chan.command;
               pos_in    = req_chan.position;
               val_in    = val_ext[VALUE_BITS-1:0];
               cur_in    = head_ff;
               idx_in    = '0;
               rd_addr   = head_ff;
               status_in = ST_OK;
               state_in  = S_RESP;
               case (req_chan.command)
                  CMD_APPEND, CMD_INSERT: begin
                     if (is_full) begin
                        status_in = ST_FULL;
                     end else if (req_chan.command == CMD_INSERT && pos_req_w > cnt_w) begin
                        status_in = ST_BAD_POS;
                     end else begin
                        // fetch the stack link now, in case the entry is reused
                        state_in = S_ALLOC;
                        rd_addr  = free_top_ff;
                        pop_in   = can_pop;
                        if (can_pop) begin
                           ent_in = free_top_ff;
                        end else begin
                           ent_in = hwm_ff[IW-1:0];
                           hwm_in = hwm_ff + CW'(1);
                        end
                     end
                  end
                  CMD_DEL_VALUE, CMD_DEL_HEAD, CMD_DUMP: begin
                     if (is_empty) begin
                        status_in = ST_EMPTY;
                     end else begin
                        state_in = S_WALK;
                     end
                  end
                  CMD_DEL_TAIL: begin
                     if (is_empty) begin
                        status_in = ST_EMPTY;
                     end else begin
                        state_in = S_WALK;
                        rd_addr  = tail_ff;
                        cur_in   = tail_ff;
                        idx_in   = count_ff - CW'(1);
                     end
                  end
                  default: begin
                     status_in = ST_OK;
                  end
               endcase
            end
         end

         S_ALLOC: begin
            if (pop_ff) begin
               free_top_in = rd_next;
            end
            rd_addr = head_ff;
            cur_in  = head_ff;
            idx_in  = '0;
            if (cmd_ff == CMD_APPEND || pos_w == cnt_w) begin
               state_in = S_LINK_TAIL;
            end else if (pos_ff == '0) begin
               state_in = S_LINK_HEAD;
            end else begin
               state_in = S_WALK;
            end
         end

         S_WALK: begin
            case (cmd_ff)
               CMD_INSERT: begin
                  if (idx_pred) begin
                     // cur_ff is the predecessor: splice the new entry after it
                     val_we   = 1'b1;
                     nxt_we   = 1'b1;
                     nxt_addr = cur_ff;
                     nxt_data = ent_ff;
                     prv_we   = 1'b1;
                     prv_addr = ent_ff;
                     prv_data = cur_ff;
                     link_in  = rd_next;
                     state_in = S_LINK_MID;
                  end else begin
                     rd_addr = rd_next;
                     cur_in  = rd_next;
                     idx_in  = idx_ff + CW'(1);
                  end
               end
               CMD_DUMP: begin
                  if (out_free) begin
                     out_load            = 1'b1;
                     out_data.status     = ST_OK;
                     out_data.item_value = item_ext[DATA_W-1:0];
                     out_data.last       = idx_last;
                     if (idx_last) begin
                        state_in = S_IDLE;
                     end else begin
                        rd_addr = rd_next;
                        cur_in  = rd_next;
                        idx_in  = idx_ff + CW'(1);
                     end
                  end
                  // otherwise re-read cur_ff and hold
               end
               default: begin
                  if (cmd_ff != CMD_DEL_VALUE || val_match) begin
                     ent_in   = cur_ff;
                     state_in = S_FREE;
                     if (idx_ff == '0 && idx_last) begin
                        head_in = '0;
                        tail_in = '0;
                     end else if (idx_ff == '0) begin
                        head_in = rd_next;
                     end else if (idx_last) begin
                        tail_in = rd_prev;
                     end else begin
                        nxt_we   = 1'b1;
                        nxt_addr = rd_prev;
                        nxt_data = rd_next;
                        prv_we   = 1'b1;
                        prv_addr = rd_next;
                        prv_data = rd_prev;
                     end
                  end else if (idx_last) begin
                     status_in = ST_NOT_FOUND;
                     state_in  = S_RESP;
                  end else begin
                     rd_addr = rd_next;
                     cur_in  = rd_next;
                     idx_in  = idx_ff + CW'(1);
                  end
               end
            endcase
         end

         S_LINK_TAIL: begin
            val_we = 1'b1;
            if (is_empty) begin
               head_in = ent_ff;
            end else begin
               nxt_we   = 1'b1;
               nxt_addr = tail_ff;
               nxt_data = ent_ff;
               prv_we   = 1'b1;
               prv_addr = ent_ff;
               prv_data = tail_ff;
            end
            tail_in   = ent_ff;
            count_in  = count_ff + CW'(1);
            status_in = ST_OK;
            state_in  = S_RESP;
         end

         S_LINK_HEAD: begin
            val_we    = 1'b1;
            nxt_we    = 1'b1;
            nxt_addr  = ent_ff;
            nxt_data  = head_ff;
            prv_we    = 1'b1;
            prv_addr  = head_ff;
            prv_data  = ent_ff;
            head_in   = ent_ff;
            count_in  = count_ff + CW'(1);
            status_in = ST_OK;
            state_in  = S_RESP;
         end

         S_LINK_MID: begin
            nxt_we    = 1'b1;
            nxt_addr  = ent_ff;
            nxt_data  = link_ff;
            prv_we    = 1'b1;
            prv_addr  = link_ff;
            prv_data  = ent_ff;
            count_in  = count_ff + CW'(1);
            status_in = ST_OK;
            state_in  = S_RESP;
         end

         S_FREE: begin
            // push the released entry on the stack of returned entries
            nxt_we      = 1'b1;
            nxt_addr    = ent_ff;
            nxt_data    = free_top_ff;
            free_top_in = ent_ff;
            count_in    = count_ff - CW'(1);
            status_in   = ST_OK;
            state_in    = S_RESP;
         end

         S_RESP: begin
            if (out_free) begin
               out_load = 1'b1;
               state_in = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= S_IDLE;
         head_ff     <= '0;
         tail_ff     <= '0;
         free_top_ff <= '0;
         count_ff    <= '0;
         hwm_ff      <= '0;
      end else begin
         state_ff    <= state_in;
         head_ff     <= head_in;
         tail_ff     <= tail_in;
         free_top_ff <= free_top_in;
         count_ff    <= count_in;
         hwm_ff      <= hwm_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff    <= cmd_in;
      pos_ff    <= pos_in;
      val_ff    <= val_in;
      cur_ff    <= cur_in;
      idx_ff    <= idx_in;
      ent_ff    <= ent_in;
      link_ff   <= link_in;
      status_ff <= status_in;
      pop_ff    <= pop_in;
   end

   dll_store #(
      .CAPACITY   (CAPACITY),
      .VALUE_BITS (VALUE_BITS)
   ) u_store (
      .clock    (clock),
      .rd_addr  (rd_addr),
      .rd_value (rd_value),
      .rd_next  (rd_next),
      .rd_prev  (rd_prev),
      .val_we   (val_we),
      .val_addr (val_addr),
      .val_data (val_data),
      .nxt_we   (nxt_we),
      .nxt_addr (nxt_addr),
      .nxt_data (nxt_data),
      .prv_we   (prv_we),
      .prv_addr (prv_addr),
      .prv_data (prv_data)
   );

   dll_out_reg u_out_reg (
      .clock     (clock),
      .reset     (reset),
      .load      (out_load),
      .load_data (out_data),
      .free      (out_free),
      .rsp_chan  (rsp_chan)
   );

   // an accepted transaction always starts work in the sequencer
   a_accept_leaves_idle: assert property (@(posedge clock) disable iff (reset)
      (req_chan.valid && req_chan.ready) |=> (state_ff != S_IDLE))
      else $error("accepted transaction left sequencer idle");

   // entries handed out never fall below entries on the list
   a_pool_balance: assert property (@(posedge clock) disable iff (reset)
      hwm_ff >= count_ff)
      else $error("pool fill count below list length");

   // results only enter the output register when it can take them
   a_load_when_free: assert property (@(posedge clock) disable iff (reset)
      out_load |-> out_free)
      else $error("result loaded into a full output register");

   // the length moves by at most one entry per cycle
   a_count_step: assert property (@(posedge clock) disable iff (reset)
      1'b1 |=> (count_ff == $past(count_ff) ||
                count_ff == $past(count_ff) + CW'(1) ||
                count_ff + CW'(1) == $past(count_ff)))
      else $error("list length jumped by more than one");

endmodule

@@ test/tb_top.sv @@
`timescale 1ns / 1ps
// Testbench for bounded_doubly_linked_list_engine_top: directed list commands, then random ones.
// Results are checked against a queue that shadows the list contents.
// Depends on dll_pkg, dll_req_if, dll_rsp_if and the engine RTL.
module tb_top;
   import dll_pkg::*;

   localparam int LIST_DEPTH    = 16;
   localparam int QUIET_LIMIT   = 2000;
   localparam int SETTLE_CYCLES = 40;

   // unused command codes: the engine answers them with a plain ok
   localparam logic [CMD_W-1:0] CMD_SPARE_6 = 3'd6;
   localparam logic [CMD_W-1:0] CMD_SPARE_7 = 3'd7;

   localparam logic signed [DATA_W-1:0] VAL_MIN = {1'b1, {(DATA_W-1){1'b0}}};
   localparam logic signed [DATA_W-1:0] VAL_MAX = ~VAL_MIN;

   logic clock = 1'b0;
   logic reset = 1'b1;

   dll_req_if req_chan ();
   dll_rsp_if rsp_chan ();

   bounded_doubly_linked_list_engine_top dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   always #4 clock = ~clock;

   // Shadow of the list, head first, and the results still owed by the engine.
   logic signed [DATA_W-1:0] list_shadow[$];
   rsp_type                  expected_rsps[$];

   int mismatches     = 0;
   int send_idle_pct  = 0;
   int recv_stall_pct = 0;
   int quiet_cycles   = 0;
   bit growing        = 1'b1;

   function automatic rsp_type make_rsp(input logic [STAT_W-1:0] st,
                                        input logic signed [DATA_W-1:0] item,
                                        input logic fin);
      rsp_type r;
      r.status     = st;
      r.item_value = item;
      r.last       = fin;
      r.length     = LEN_W'(list_shadow.size());
      return r;
   endfunction

   // Apply one accepted command to the shadow list and queue the results it owes.
   task automatic apply_list_command(input logic [CMD_W-1:0] cmd,
                                     input logic [POS_W-1:0] pos,
                                     input logic signed [DATA_W-1:0] val);
      logic [STAT_W-1:0] st;
      int hit;
      st  = ST_OK;
      hit = -1;
      case (cmd)
         CMD_APPEND: begin
            if (list_shadow.size() >= LIST_DEPTH) st = ST_FULL;
            else list_shadow.push_back(val);
         end
         CMD_INSERT: begin
            if (list_shadow.size() >= LIST_DEPTH) st = ST_FULL;
            else if (pos > list_shadow.size()) st = ST_BAD_POS;
            else list_shadow.insert(int'(pos), val);
         end
         CMD_DEL_VALUE: begin
            if (list_shadow.size() == 0) begin
               st = ST_EMPTY;
            end else begin
               foreach (list_shadow[i]) begin
                  if (hit < 0 && list_shadow[i] == val) hit = i;
               end
               if (hit < 0) st = ST_NOT_FOUND;
               else list_shadow.delete(hit);
            end
         end
         CMD_DEL_HEAD: begin
            if (list_shadow.size() == 0) st = ST_EMPTY;
            else void'(list_shadow.pop_front());
         end
         CMD_DEL_TAIL: begin
            if (list_shadow.size() == 0) st = ST_EMPTY;
            else void'(list_shadow.pop_back());
         end
         CMD_DUMP: begin
            if (list_shadow.size() == 0) begin
               st = ST_EMPTY;
            end else begin
               // one transaction per entry, head to tail, last on the tail
               foreach (list_shadow[i]) begin
                  expected_rsps.push_back(make_rsp(ST_OK, list_shadow[i],
                                                   i == list_shadow.size() - 1));
               end
               return;
            end
         end
         default: ;
      endcase
      expected_rsps.push_back(make_rsp(st, '0, 1'b1));
   endtask

   // Drive one command and hold it until the engine takes it. Valid is left high
   // on return so a back-to-back command needs no second assignment in this step.
   task automatic send_command(input logic [CMD_W-1:0] cmd,
                               input logic [POS_W-1:0] pos,
                               input logic signed [DATA_W-1:0] val);
      if ($urandom_range(99) < send_idle_pct) begin
         req_chan.valid <= 1'b0;
         @(posedge clock);
         while ($urandom_range(99) < send_idle_pct) @(posedge clock);
      end
      req_chan.valid    <= 1'b1;
      req_chan.command  <= cmd;
      req_chan.position <= pos;
      req_chan.value    <= val;
      @(posedge clock);
      while (req_chan.ready !== 1'b1) @(posedge clock);
      apply_list_command(cmd, pos, val);
   endtask

   // Drop valid and hold off until every owed result has come back.
   task automatic drain_results();
      req_chan.valid <= 1'b0;
      @(posedge clock);
      while (expected_rsps.size() != 0) @(posedge clock);
   endtask

   // Empty-list corner cases, then insert at position zero on an empty list,
   // which has to set the tail too: a delete of the tail must then find it.
   task automatic test_empty_list();
      send_command(CMD_DUMP, '0, '0);
      send_command(CMD_DEL_HEAD, '0, '0);
      send_command(CMD_DEL_TAIL, '0, '0);
      send_command(CMD_DEL_VALUE, '0, 5);
      send_command(CMD_INSERT, 1, 7);
      send_command(CMD_INSERT, 0, VAL_MAX);
      send_command(CMD_DEL_TAIL, '0, '0);
      send_command(CMD_DUMP, '0, '0);
   endtask

   // Value extremes, insert at the length, at the head, in the middle and far
   // past the end, the spare codes, and deletes from each part of the list.
   task automatic test_edge_inserts();
      send_command(CMD_APPEND, '0, VAL_MIN);
      send_command(CMD_INSERT, 1, -1);
      send_command(CMD_INSERT, 0, 0);
      send_command(CMD_INSERT, 1, VAL_MAX);
      send_command(CMD_INSERT, '1, 5);
      send_command(CMD_SPARE_6, '1, '1);
      send_command(CMD_SPARE_7, '0, '0);
      send_command(CMD_DUMP, '0, '0);
      send_command(CMD_DEL_VALUE, '0, 12345);
      send_command(CMD_DEL_VALUE, '0, -1);
      send_command(CMD_DEL_VALUE, '0, VAL_MAX);
      send_command(CMD_DEL_HEAD, '0, '0);
      send_command(CMD_DEL_TAIL, '0, '0);
      send_command(CMD_DUMP, '0, '0);
   endtask

   // Random commands. Swing between growing and shrinking so the list keeps
   // running into both full and empty; draw values mostly from the list and a
   // small pool so that deletes by value hit, duplicates included.
   task automatic test_random_traffic(input int idle_pct, input int stall_pct,
                                      input int count);
      logic [CMD_W-1:0]         cmd;
      logic [POS_W-1:0]         pos;
      logic signed [DATA_W-1:0] val;
      int pick;
      send_idle_pct  = idle_pct;
      recv_stall_pct = stall_pct;
      repeat (count) begin
         if (list_shadow.size() == LIST_DEPTH) growing = 1'b0;
         else if (list_shadow.size() == 0) growing = 1'b1;

         pick = $urandom_range(99);
         if (pick < 3) cmd = pick[0] ? CMD_SPARE_7 : CMD_SPARE_6;
         else if (pick < 12) cmd = CMD_DUMP;
         else if (growing) cmd = (pick < 52) ? CMD_APPEND :
                                 (pick < 82) ? CMD_INSERT :
                                 (pick < 90) ? CMD_DEL_VALUE :
                                 (pick < 95) ? CMD_DEL_HEAD : CMD_DEL_TAIL;
         else cmd = (pick < 22) ? CMD_APPEND :
                    (pick < 30) ? CMD_INSERT :
                    (pick < 60) ? CMD_DEL_VALUE :
                    (pick < 80) ? CMD_DEL_HEAD : CMD_DEL_TAIL;

         // mostly legal positions, now and then anything the field can hold
         if ($urandom_range(4) == 0) pos = POS_W'($urandom_range(31));
         else pos = POS_W'($urandom_range(list_shadow.size()));

         pick = $urandom_range(99);
         if (list_shadow.size() != 0 && pick < ((cmd == CMD_DEL_VALUE) ? 70 : 25)) begin
            val = list_shadow[$urandom_range(list_shadow.size() - 1)];
         end else if (pick < 85) begin
            val = $urandom_range(15);
            val = val - 8;
         end else begin
            val = $urandom();
         end
         send_command(cmd, pos, val);
      end
      drain_results();
   endtask

   function automatic void compare_field(input string name,
                                         input logic [DATA_W-1:0] want,
                                         input logic [DATA_W-1:0] got);
      if (got !== want) begin
         $error("%s: expected 0x%0h, actual 0x%0h", name, want, got);
         mismatches++;
      end
   endfunction

   // Check every accepted result against the oldest owed one, then pick the
   // receiver's ready for the next cycle.
   always @(posedge clock) begin : result_check
      rsp_type want;
      if (!reset && rsp_chan.valid === 1'b1 && rsp_chan.ready === 1'b1) begin
         if (expected_rsps.size() == 0) begin
            $error("result with none owed: status %0d item_value 0x%0h last %0d length %0d",
                   rsp_chan.status, rsp_chan.item_value, rsp_chan.last, rsp_chan.length);
            mismatches++;
         end else begin
            want = expected_rsps.pop_front();
            compare_field("status", want.status, rsp_chan.status);
            compare_field("item_value", want.item_value, rsp_chan.item_value);
            compare_field("last", want.last, rsp_chan.last);
            compare_field("length", want.length, rsp_chan.length);
         end
      end
      rsp_chan.ready <= ($urandom_range(99) >= recv_stall_pct);
   end

   // Stop the run if no transaction moves on either channel for too long.
   always @(posedge clock) begin
      if ((req_chan.valid === 1'b1 && req_chan.ready === 1'b1) ||
          (rsp_chan.valid === 1'b1 && rsp_chan.ready === 1'b1)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("bounded_doubly_linked_list_engine_top test failed");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      // every input known from time zero
      req_chan.valid    = 1'b0;
      req_chan.command  = CMD_APPEND;
      req_chan.position = '0;
      req_chan.value    = '0;
      rsp_chan.ready    = 1'b0;

      // hold reset, then release it
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      test_empty_list();
      test_edge_inserts();
      drain_results();

      // idling phases: none, sender only, receiver only, both
      test_random_traffic(0, 0, 25);
      test_random_traffic(46, 0, 25);
      test_random_traffic(0, 46, 25);
      test_random_traffic(36, 36, 25);

      // let any stray transaction show up before judging
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (expected_rsps.size() != 0) begin
         $error("%0d results never arrived", expected_rsps.size());
         mismatches++;
      end
      if (mismatches == 0) begin
         $display("bounded_doubly_linked_list_engine_top test passed");
      end else begin
         $display("bounded_doubly_linked_list_engine_top test failed");
      end
      $finish;
   end

endmodule

@@ sim.f @@
rtl/core/dll_pkg.sv
rtl/core/dll_req_if.sv
rtl/core/dll_rsp_if.sv
rtl/core/dll_store.sv
rtl/core/dll_out_reg.sv
rtl/core/bounded_doubly_linked_list_engine_top.sv
test/tb_top.sv
